/* design/edr_pkg.sv */
// package for the encoder dead reckoning block: types, constants, tables
`timescale 1ns / 1ps
`default_nettype none
package edr_pkg;
	localparam int POS_W = 40;
	localparam int DPP_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int HEAD_W = 16;
	localparam int TRIG_W = 34;
	localparam int DIST_W = 33;
	localparam int ATAN_N = 25;

	localparam logic [CFG_IDX_W-1:0] REG_DPP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd2;

	localparam logic signed [TRIG_W-1:0] CORDIC_K = 34'sd652032874;
	localparam logic signed [POS_W-1:0] POS_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 40'sh80_0000_0000;

	// binary angle = heading * 119304 + floor((heading * 728 + 562) / 1125)
	localparam logic [16:0] HEAD_BASE = 17'd119304;
	localparam logic [9:0] HEAD_MUL = 10'd728;
	localparam logic [9:0] HEAD_BIAS = 10'd562;
	localparam logic [26:0] HEAD_RECIP = 27'd122167959;
	localparam int HEAD_RSH = 37;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_CORDIC,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic angle;
		logic cordic;
		logic mul;
		logic acc;
	} dp_cmd_t;

	typedef struct packed {
		logic angle_done;
		logic cordic_done;
		logic mul_done;
	} dp_sts_t;

	function automatic logic signed [TRIG_W-1:0] atan_val(input logic [4:0] i);
		logic signed [TRIG_W-1:0] r;
		begin
			unique case (i)
				5'd0: r = 34'sd536870912;
				5'd1: r = 34'sd316933406;
				5'd2: r = 34'sd167458907;
				5'd3: r = 34'sd85004756;
				5'd4: r = 34'sd42667331;
				5'd5: r = 34'sd21354465;
				5'd6: r = 34'sd10679838;
				5'd7: r = 34'sd5340245;
				5'd8: r = 34'sd2670163;
				5'd9: r = 34'sd1335087;
				5'd10: r = 34'sd667544;
				5'd11: r = 34'sd333772;
				5'd12: r = 34'sd166886;
				5'd13: r = 34'sd83443;
				5'd14: r = 34'sd41722;
				5'd15: r = 34'sd20861;
				5'd16: r = 34'sd10430;
				5'd17: r = 34'sd5215;
				5'd18: r = 34'sd2608;
				5'd19: r = 34'sd1304;
				5'd20: r = 34'sd652;
				5'd21: r = 34'sd326;
				5'd22: r = 34'sd163;
				5'd23: r = 34'sd81;
				5'd24: r = 34'sd41;
				default: r = '0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

/* design/edr_if.sv */
// valid/ready channel interfaces for encoder samples and positions
`timescale 1ns / 1ps
`default_nettype none
interface edr_in_if;
	logic valid;
	logic ready;
	logic left_a;
	logic left_b;
	logic right_a;
	logic right_b;
	logic update;
	logic [15:0] heading;
	modport source(output valid, left_a, left_b, right_a, right_b, update, heading,
		input ready);
	modport sink(input valid, left_a, left_b, right_a, right_b, update, heading,
		output ready);
endinterface

interface edr_out_if;
	logic valid;
	logic ready;
	logic signed [39:0] pos_x;
	logic signed [39:0] pos_y;
	modport source(output valid, pos_x, pos_y, input ready);
	modport sink(input valid, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

/* design/edr_ctrl.sv */
// controller state machine sequencing one item through the datapath
`timescale 1ns / 1ps
`default_nettype none
module edr_ctrl
	import edr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_update,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire dp_sts_t sts,
	output dp_cmd_t cmd
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = in_update ? ST_ANGLE : ST_OUT;
			ST_ANGLE: if (sts.angle_done) state_nx = ST_CORDIC;
			ST_CORDIC: if (sts.cordic_done) state_nx = ST_MUL;
			ST_MUL: if (sts.mul_done) state_nx = ST_ACC;
			ST_ACC: state_nx = ST_OUT;
			ST_OUT: if (out_ready) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.start = in_valid;
			end
			ST_ANGLE: cmd.angle = 1'b1;
			ST_CORDIC: cmd.cordic = 1'b1;
			ST_MUL: cmd.mul = 1'b1;
			ST_ACC: cmd.acc = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* design/edr_dp.sv */
// datapath: edge counters, heading scaling, cordic, multiplier, position accumulators
`timescale 1ns / 1ps
`default_nettype none
module edr_dp
	import edr_pkg::*;
#(
	parameter int COUNT_WIDTH = 32,
	parameter int POSITION_FRAC_BITS = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic left_a,
	input wire logic left_b,
	input wire logic right_a,
	input wire logic right_b,
	input wire logic [HEAD_W-1:0] heading,
	input wire dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y
);
	localparam int ITER = (TRIG_ITERATIONS < ATAN_N) ? TRIG_ITERATIONS : ATAN_N;
	localparam int SH = 46 - POSITION_FRAC_BITS;
	localparam int DW = (COUNT_WIDTH > 36) ? 37 : COUNT_WIDTH + 1;
	localparam int PW = DIST_W + TRIG_W;

	logic [DPP_W-1:0] dpp_q;
	logic [COUNT_WIDTH-1:0] lcnt_q, rcnt_q, lseen_q, rseen_q;
	logic la_last_q, ra_last_q;
	logic signed [POS_W-1:0] x_q, y_q;
	logic [COUNT_WIDTH-1:0] lcnt_nx, rcnt_nx;
	logic signed [DW:0] dsum_q;
	logic signed [DIST_W-1:0] dist_q;
	logic [25:0] m_q;
	logic [31:0] base_q;
	logic [15:0] quo_q;
	logic [5:0] step_q;
	logic neg_q;
	logic signed [TRIG_W-1:0] cx_q, cy_q, cz_q;
	logic signed [PW-1:0] px_q, py_q;

	function automatic logic signed [POS_W-1:0] start_conv(input logic [31:0] v);
		logic signed [POS_W+15:0] s;
		begin
			s = $signed({{(POS_W - 24) {v[31]}}, v, 8'd0});
			return POS_W'(s >>> (24 - POSITION_FRAC_BITS));
		end
	endfunction

	// count deltas, clamping and the distance product
	logic [COUNT_WIDTH-1:0] ldiff, rdiff;
	logic signed [DW-1:0] dl, dr;
	logic signed [DW:0] dsum;
	logic signed [DW+DPP_W+1:0] dprod;
	logic signed [DW+DPP_W:0] dhalf;
	logic signed [DIST_W-1:0] dist_c;
	always_comb begin
		ldiff = lcnt_q - lseen_q;
		rdiff = rcnt_q - rseen_q;
		if (COUNT_WIDTH > 36) begin
			dl = ($signed(ldiff) > $signed(64'sd34359738368)) ? DW'(64'sd34359738368) :
				($signed(ldiff) < -$signed(64'sd34359738368)) ? DW'(-64'sd34359738368) :
				DW'($signed(ldiff));
			dr = ($signed(rdiff) > $signed(64'sd34359738368)) ? DW'(64'sd34359738368) :
				($signed(rdiff) < -$signed(64'sd34359738368)) ? DW'(-64'sd34359738368) :
				DW'($signed(rdiff));
		end else begin
			dl = DW'($signed(ldiff));
			dr = DW'($signed(rdiff));
		end
		dsum = (DW+1)'(dl) + (DW+1)'(dr);
		dprod = (DW+DPP_W+2)'(dsum_q) * $signed({1'b0, dpp_q});
		dhalf = dprod[DW+DPP_W+1:1];
		if (dhalf > (DW+DPP_W+1)'(64'sd4294967295)) dist_c = 33'sd4294967295;
		else if (dhalf < -(DW+DPP_W+1)'(64'sd4294967295)) dist_c = -33'sd4294967295;
		else dist_c = DIST_W'(dhalf);
	end

	always_comb begin
		lcnt_nx = lcnt_q;
		rcnt_nx = rcnt_q;
		if (left_a && !la_last_q) lcnt_nx = left_b ? lcnt_q + 1'b1 : lcnt_q - 1'b1;
		if (right_a && !ra_last_q) rcnt_nx = right_b ? rcnt_q + 1'b1 : rcnt_q - 1'b1;
	end

	// reciprocal multiply for the remainder part of heading * 2^32 / 36000
	logic [52:0] rprod;
	logic [31:0] a_raw;
	logic [1:0] aq;
	assign rprod = {27'd0, m_q} * {26'd0, HEAD_RECIP};
	assign a_raw = base_q + {16'd0, quo_q};
	assign aq = a_raw[31:30];

	// cordic step
	logic signed [TRIG_W-1:0] xs, ys;
	logic [4:0] it;
	assign it = 5'(step_q - 6'd1);
	assign xs = cx_q >>> it;
	assign ys = cy_q >>> it;

	logic signed [TRIG_W-1:0] mul_t;
	logic signed [PW-1:0] mul_p;
	assign mul_t = step_q[0] ? cy_q : cx_q;
	assign mul_p = PW'(dist_q) * PW'(mul_t);

	logic signed [PW:0] rx, ry;
	logic signed [POS_W+1:0] sx, sy;
	assign rx = ((PW+1)'(px_q) + ((PW+1)'(1) <<< (SH - 1))) >>> SH;
	assign ry = ((PW+1)'(py_q) + ((PW+1)'(1) <<< (SH - 1))) >>> SH;
	assign sx = (POS_W+2)'(x_q) + (POS_W+2)'(rx);
	assign sy = (POS_W+2)'(y_q) + (POS_W+2)'(ry);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpp_q <= DPP_W'(65536);
			lcnt_q <= '0;
			rcnt_q <= '0;
			lseen_q <= '0;
			rseen_q <= '0;
			la_last_q <= 1'b1;
			ra_last_q <= 1'b1;
			x_q <= '0;
			y_q <= '0;
			step_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_DPP: dpp_q <= cfg_data[DPP_W-1:0];
					REG_START_X: x_q <= start_conv(cfg_data);
					REG_START_Y: y_q <= start_conv(cfg_data);
					default: ;
				endcase
			end
			if (cmd.start) begin
				lcnt_q <= lcnt_nx;
				rcnt_q <= rcnt_nx;
				la_last_q <= left_a;
				ra_last_q <= right_a;
				step_q <= '0;
			end
			if (cmd.angle) begin
				step_q <= (step_q == 6'd1) ? '0 : step_q + 1'b1;
				if (step_q == '0) begin
					lseen_q <= lcnt_q;
					rseen_q <= rcnt_q;
				end
			end
			if (cmd.cordic) begin
				step_q <= (step_q == 6'(ITER + 1)) ? '0 : step_q + 1'b1;
			end
			if (cmd.mul) step_q <= step_q + 1'b1;
			if (cmd.acc) begin
				x_q <= (sx > (POS_W+2)'(POS_MAX)) ? POS_MAX :
					(sx < (POS_W+2)'(POS_MIN)) ? POS_MIN : POS_W'(sx);
				y_q <= (sy > (POS_W+2)'(POS_MAX)) ? POS_MAX :
					(sy < (POS_W+2)'(POS_MIN)) ? POS_MIN : POS_W'(sy);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			m_q <= {10'd0, heading} * {16'd0, HEAD_MUL} + {16'd0, HEAD_BIAS};
			base_q <= 32'({17'd0, heading} * {16'd0, HEAD_BASE});
		end
		if (cmd.angle) begin
			if (step_q == '0) begin
				quo_q <= rprod[HEAD_RSH+15:HEAD_RSH];
				dsum_q <= dsum;
			end else begin
				dist_q <= dist_c;
			end
		end
		if (cmd.cordic) begin
			if (step_q == '0) begin
				neg_q <= (aq == 2'd1) || (aq == 2'd2);
				cx_q <= CORDIC_K;
				cy_q <= '0;
				cz_q <= TRIG_W'($signed(((aq == 2'd1) || (aq == 2'd2)) ?
					(a_raw ^ 32'h8000_0000) : a_raw));
			end else if (step_q != 6'(ITER + 1)) begin
				if (!cz_q[TRIG_W-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atan_val(it);
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atan_val(it);
				end
			end else if (neg_q) begin
				cx_q <= -cx_q;
				cy_q <= -cy_q;
			end
		end
		if (cmd.mul) begin
			if (!step_q[0]) px_q <= mul_p;
			else py_q <= mul_p;
		end
	end

	always_comb begin
		sts.angle_done = (step_q == 6'd1);
		sts.cordic_done = (step_q == 6'(ITER + 1));
		sts.mul_done = step_q[0];
	end

	assign pos_x = x_q;
	assign pos_y = y_q;
endmodule
`default_nettype wire

/* design/encoder_dead_reckoning.sv */
// top level of the two-wheel encoder dead reckoning block
`timescale 1ns / 1ps
`default_nettype none
// One item per encoder sample; each returns the current position. An item without
// update goes straight to the output state; an item with update passes the count
// deltas and the reciprocal heading scaling, the cordic steps (an initial load, up to
// TRIG_ITERATIONS rotations, at most 25, and a sign fix), two multiplier passes and
// one accumulate before its output. A held-off output holds the item until it is
// taken. One item is in flight at a time.
module encoder_dead_reckoning
	import edr_pkg::*;
#(
	parameter int COUNT_WIDTH = 32,
	parameter int POSITION_FRAC_BITS = 16,
	parameter int TRIG_ITERATIONS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	edr_in_if.sink in_ch,
	edr_out_if.source out_ch
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	edr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_update(in_ch.update),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts(sts),
		.cmd(cmd)
	);

	edr_dp #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.POSITION_FRAC_BITS(POSITION_FRAC_BITS),
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.left_a(in_ch.left_a),
		.left_b(in_ch.left_b),
		.right_a(in_ch.right_a),
		.right_b(in_ch.right_b),
		.heading(in_ch.heading),
		.cmd(cmd),
		.sts(sts),
		.pos_x(out_ch.pos_x),
		.pos_y(out_ch.pos_y)
	);
endmodule
`default_nettype wire

/* tb/tb_encoder_dead_reckoning.sv */
// testbench for encoder_dead_reckoning: odometry predictor, scoreboard, random traffic
`timescale 1ns / 1ps
module tb_encoder_dead_reckoning;
	import edr_pkg::*;

	typedef struct {
		bit la;
		bit lb;
		bit ra;
		bit rb;
		bit upd;
		bit [15:0] hdg;
	} sample_t;

	class odometry_board;
		int unsigned left_cnt, right_cnt, left_seen, right_seen;
		bit left_last, right_last;
		longint px, py;
		int unsigned dpp;
		logic [39:0] want_x[$];
		logic [39:0] want_y[$];
		longint atan_steps[16] = '{536870912, 316933406, 167458907, 85004756,
			42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
			333772, 166886, 83443, 41722, 20861};

		function new();
			left_cnt = 0;
			right_cnt = 0;
			left_seen = 0;
			right_seen = 0;
			left_last = 1;
			right_last = 1;
			px = 0;
			py = 0;
			dpp = 65536;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			if (idx == REG_DPP)
				dpp = val[23:0];
			else if (idx == REG_START_X)
				px = longint'($signed(val));
			else if (idx == REG_START_Y)
				py = longint'($signed(val));
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void heading_trig(bit [15:0] hdg, output longint c, output longint s);
			longint unsigned num;
			bit [31:0] ang;
			bit flip;
			longint x, y, z, nx;
			num = ((64'(hdg)) << 32) + 64'd18000;
			num = num / 64'd36000;
			ang = num[31:0];
			flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
			if (flip)
				ang[31] = ~ang[31];
			z = longint'($signed(ang));
			x = 652032874;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z = z - atan_steps[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z = z + atan_steps[i];
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint step_of(longint d, longint t);
			return (d * t + (64'sd1 <<< 29)) >>> 30;
		endfunction

		function void note(sample_t it);
			longint dl, dr, travel, c, s;
			if (it.la && !left_last)
				left_cnt = it.lb ? left_cnt + 1 : left_cnt - 1;
			if (it.ra && !right_last)
				right_cnt = it.rb ? right_cnt + 1 : right_cnt - 1;
			left_last = it.la;
			right_last = it.ra;
			if (it.upd) begin
				dl = longint'($signed(left_cnt - left_seen));
				dr = longint'($signed(right_cnt - right_seen));
				left_seen = left_cnt;
				right_seen = right_cnt;
				travel = ((dl + dr) * longint'(dpp)) >>> 1;
				travel = clip(travel, -64'sd4294967295, 64'sd4294967295);
				heading_trig(it.hdg, c, s);
				px = clip(px + step_of(travel, c), -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
				py = clip(py + step_of(travel, s), -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
			end
			want_x.push_back(px[39:0]);
			want_y.push_back(py[39:0]);
		endfunction

		function int check(logic [39:0] gx, logic [39:0] gy, output string msg);
			logic [39:0] ex, ey;
			if (want_x.size() == 0) begin
				msg = $sformatf("position with none pending x=%h y=%h", gx, gy);
				return 1;
			end
			ex = want_x.pop_front();
			ey = want_y.pop_front();
			if (gx !== ex || gy !== ey) begin
				msg = $sformatf("position x=%h y=%h, wanted x=%h y=%h", gx, gy, ex, ey);
				return 1;
			end
			return 0;
		endfunction

		function int pending();
			return want_x.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int errors;
	bit idle_on;
	bit hold_req;
	odometry_board board;
	bit [1:0] wheel_ph[2];
	bit wheel_dir[2];

	edr_in_if in_ch();
	edr_out_if out_ch();

	encoder_dead_reckoning u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task report(string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	always @(posedge clk) begin
		string msg;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (board.check(out_ch.pos_x, out_ch.pos_y, msg))
				report(msg);
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	task send(sample_t it);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.left_a <= it.la;
		in_ch.left_b <= it.lb;
		in_ch.right_a <= it.ra;
		in_ch.right_b <= it.rb;
		in_ch.update <= it.upd;
		in_ch.heading <= it.hdg;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		board.note(it);
	endtask

	task send_pins(bit la, bit lb, bit ra, bit rb, bit upd, bit [15:0] hdg);
		sample_t it;
		it.la = la;
		it.lb = lb;
		it.ra = ra;
		it.rb = rb;
		it.upd = upd;
		it.hdg = hdg;
		send(it);
	endtask

	// wait for every position, then let the block sit idle before the next section
	task drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	function sample_t random_sample();
		sample_t it;
		bit [1:0] g;
		for (int w = 0; w < 2; w++) begin
			if ($urandom_range(0, 15) == 0)
				wheel_dir[w] = ~wheel_dir[w];
			if ($urandom_range(0, 3) != 0)
				wheel_ph[w] = wheel_dir[w] ? wheel_ph[w] + 2'd1 : wheel_ph[w] - 2'd1;
			else
				wheel_ph[w] = 2'($urandom_range(0, 3));
		end
		g = wheel_ph[0] ^ (wheel_ph[0] >> 1);
		it.la = g[1];
		it.lb = g[0];
		g = wheel_ph[1] ^ (wheel_ph[1] >> 1);
		it.ra = g[1];
		it.rb = g[0];
		it.upd = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 9) == 0)
			it.hdg = 16'($urandom_range(0, 65535));
		else
			it.hdg = 16'($urandom_range(0, 35999));
		return it;
	endfunction

	task random_run(int n);
		for (int i = 0; i < n; i++)
			send(random_sample());
	endtask

	initial begin
		board = new();
		errors = 0;
		idle_on = 1;
		hold_req = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.left_a = 1'b0;
		in_ch.left_b = 1'b0;
		in_ch.right_a = 1'b0;
		in_ch.right_b = 1'b0;
		in_ch.update = 1'b0;
		in_ch.heading = '0;
		wheel_ph = '{0, 0};
		wheel_dir = '{1, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset values, directed: edges both ways, headings, update without edges
		send_pins(1, 1, 1, 1, 1, 16'd0);
		send_pins(0, 1, 0, 0, 0, 16'd0);
		send_pins(1, 1, 1, 0, 1, 16'd0);
		send_pins(0, 0, 0, 1, 0, 16'd0);
		send_pins(1, 1, 1, 1, 1, 16'd9000);
		send_pins(0, 0, 0, 0, 1, 16'd18000);
		send_pins(1, 0, 1, 0, 1, 16'd27000);
		send_pins(0, 1, 0, 1, 0, 16'd0);
		send_pins(1, 1, 1, 1, 1, 16'd35999);
		send_pins(0, 1, 0, 1, 0, 16'd0);
		send_pins(1, 1, 1, 1, 1, 16'd65535);
		send_pins(0, 1, 0, 1, 0, 16'd0);
		send_pins(1, 1, 1, 1, 1, 16'd4500);
		send_pins(1, 1, 1, 1, 1, 16'd13500);
		send_pins(0, 0, 0, 0, 1, 16'd22500);
		send_pins(1, 0, 1, 0, 1, 16'd31500);
		send_pins(0, 1, 0, 1, 1, 16'd36000);
		drain();

		// extremes: largest distance per pulse, starts at the corners
		write_reg(REG_DPP, 32'h00FF_FFFF);
		write_reg(REG_START_X, 32'h7FFF_FFFF);
		write_reg(REG_START_Y, 32'h8000_0000);
		// long run of forward edges so the distance clamps
		for (int i = 0; i < 540; i++)
			send_pins(i[0], 1, i[0], 1, 0, 16'd0);
		send_pins(0, 1, 0, 1, 1, 16'd4500);
		for (int i = 0; i < 540; i++)
			send_pins(i[0], 0, i[0], 0, i == 539, 16'd22500);
		hold_req = 1;
		random_run(100);
		drain();

		write_reg(REG_DPP, 32'h0000_0000);
		write_reg(REG_START_X, 32'h8000_0000);
		write_reg(REG_START_Y, 32'h7FFF_FFFF);
		random_run(50);
		drain();

		write_reg(REG_DPP, $urandom_range(0, 24'hFF_FFFF));
		write_reg(REG_START_X, $urandom);
		write_reg(REG_START_Y, $urandom);
		random_run(100);
		drain();

		idle_on = 0;
		write_reg(REG_DPP, 32'h0001_0000);
		random_run(100);
		drain();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
